/* sv/hmpq_pkg.sv */
// ----------------------------------------------------------------------------
// hmpq_pkg
// Shared types and codes for the max-heap priority queue.
// ----------------------------------------------------------------------------
package hmpq_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam logic signed [KEY_W-1:0] NONE_VALUE = -32'sd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_ROOT,
        S_DN_LAST,
        S_DN_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

/* sv/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit keys held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, action, key): action 0 inserts key,
//   action 1 extracts the largest key. One transaction is processed at a time;
//   in_ready is high only while the sequencer is idle.
//   Output channel (out_valid/out_ready, value, status, count): one result per
//   input transaction, in order. value is the extracted key (-1 on insert or
//   empty extract), status is ok / empty / full, count is the element count
//   after the operation.
//   in_ready returns as out_valid rises.
//   One RAM read port, registered read: a sift-up level is one read and
//   a compare, a sift-down level two child reads. The sifting key stays in a
//   register, displaced entries are written one per level.
//   Reset clears the element count and out_valid; the RAM is not
//   cleared. A stalled receiver holds the result in the output register; the
//   next transaction is still accepted and worked, then waits for it.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [hmpq_pkg::KEY_W-1:0]   key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hmpq_pkg::KEY_W-1:0]   value,
    output logic [hmpq_pkg::STATUS_W-1:0]       status,
    output logic [hmpq_pkg::COUNT_W-1:0]        count
);

    import hmpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;

    state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           cidx_reg, cidx_next;
    logic signed [KEY_W-1:0] mov_reg, mov_next;
    logic signed [KEY_W-1:0] child_reg, child_next;
    logic                    rc_ok_reg, rc_ok_next;
    logic signed [KEY_W-1:0] res_value_reg, res_value_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [KEY_W-1:0] value_reg, value_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [COUNT_W-1:0]      count_out_reg, count_out_next;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [KEY_W-1:0]        wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [KEY_W-1:0]        rd_data;
    logic signed [KEY_W-1:0] rd_key;

    logic [AW-1:0]           parent;
    logic [IW-1:0]           lc, rc, n_ext;
    logic signed [KEY_W-1:0] best_key;
    logic [AW-1:0]           best_idx;
    logic [CW+COUNT_W-1:0]   count_ext;

    hmpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key    = $signed(rd_data);
    assign parent    = AW'((pos_reg - AW'(1)) >> 1);
    assign lc        = IW'({pos_reg, 1'b1});
    assign rc        = lc + IW'(1);
    assign n_ext     = IW'(count_reg);
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    // right child wins only when strictly greater; ties go left
    always_comb
    begin
        if (rc_ok_reg && (rd_key > child_reg))
        begin
            best_key = rd_key;
            best_idx = AW'(cidx_reg + AW'(1));
        end
        else
        begin
            best_key = child_reg;
            best_idx = cidx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cidx_reg       <= cidx_next;
        mov_reg        <= mov_next;
        child_reg      <= child_next;
        rc_ok_reg      <= rc_ok_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        count_out_reg  <= count_out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        cidx_next       = cidx_reg;
        mov_next        = mov_reg;
        child_next      = child_reg;
        rc_ok_next      = rc_ok_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        value_next      = value_reg;
        status_next     = status_reg;
        count_out_next  = count_out_reg;
        in_ready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = mov_reg;
        rd_en           = 1'b0;
        rd_addr         = parent;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                res_value_next  = NONE_VALUE;
                res_status_next = ST_OK;
                if (in_valid)
                begin
                    if (action == ACT_INSERT)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mov_next   = key;
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_DN_ROOT;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (mov_reg > rd_key)
                begin
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DN_ROOT:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_DN_LAST;
            end

            S_DN_LAST:
            begin
                res_value_next = rd_key;
                rd_en          = 1'b1;
                rd_addr        = AW'(count_reg);
                state_next     = S_DN_LOAD;
            end

            S_DN_LOAD:
            begin
                mov_next   = rd_key;
                pos_next   = '0;
                state_next = (count_reg == '0) ? S_DONE : S_DN_RDL;
            end

            S_DN_RDL:
            begin
                if (lc >= n_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(lc);
                    cidx_next  = AW'(lc);
                    state_next = S_DN_RDR;
                end
            end

            S_DN_RDR:
            begin
                child_next = rd_key;
                rc_ok_next = (rc < n_ext);
                rd_en      = (rc < n_ext);
                rd_addr    = AW'(rc);
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (best_key > mov_reg)
                begin
                    wr_data    = best_key;
                    pos_next   = best_idx;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_value_reg;
                    status_next    = res_status_reg;
                    count_out_next = count_ext[COUNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

/* sv/hmpq_ram.sv */
// ----------------------------------------------------------------------------
// hmpq_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hmpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/hmpq_checker.sv */
// ----------------------------------------------------------------------------
// hmpq_checker
// Port-level checks on the max-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module hmpq_checker #(
    parameter int CAPACITY = 1024
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                action,
    input logic signed [hmpq_pkg::KEY_W-1:0]   key,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [hmpq_pkg::KEY_W-1:0]   value,
    input logic [hmpq_pkg::STATUS_W-1:0]       status,
    input logic [hmpq_pkg::COUNT_W-1:0]        count
);

    import hmpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW+COUNT_W-1:0] CAP_EXT = (CW + COUNT_W)'(CAPACITY);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value)
            && $stable(status) && $stable(count))
        else $error("stalled result changed");

    // one transaction at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (value == NONE_VALUE) && (count == '0))
        else $error("empty extract result malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL)
            |-> (value == NONE_VALUE) && (count == CAP_EXT[COUNT_W-1:0]))
        else $error("full insert result malformed");

endmodule

bind max_heap_priority_queue hmpq_checker #(
    .CAPACITY (CAPACITY)
) u_hmpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status),
    .count     (count)
);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_heap_priority_queue. Each accepted insert or
// extract runs through a software max-heap, and the expected value, status
// and count are queued. Results are checked in order against that queue.
// The stimulus runs directed cases and a random mix, fills the heap to
// capacity, pushes into the full heap, then runs an extract-heavy mix with
// random idle gaps on both channels and long output stalls backing up input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmpq_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int HEAP_DEPTH   = 1024;
    localparam int MAX_GAP      = 5;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] key;
    } heap_op_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      count;
    } heap_result_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic                       action    = ACT_INSERT;
    logic signed [KEY_W-1:0]    key       = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [KEY_W-1:0]    value;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         count;

    // software heap
    logic signed [KEY_W-1:0]    heap_keys [HEAP_DEPTH];
    int                         heap_size = 0;

    heap_op_t                   pending_ops[$];
    heap_result_t               expected_results[$];
    int                         plan_size = 0;   // heap size as seen while building stimulus

    int                         in_acc      = 0;
    int                         out_acc     = 0;
    int                         tx_sent     = 0;
    int                         idle_cycles = 0;
    int                         fail_cnt    = 0;

    max_heap_priority_queue #(
        .CAPACITY (HEAP_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status),
        .count     (count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void heap_swap(int a, int b);
        logic signed [KEY_W-1:0] t;
        t            = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic heap_result_t heap_apply(logic act, logic signed [KEY_W-1:0] k);
        heap_result_t r;
        int           pos;
        int           up;
        int           lc;
        int           rc;
        int           big;
        r.value  = NONE_VALUE;
        r.status = ST_OK;
        if (act == ACT_INSERT)
        begin
            if (heap_size >= HEAP_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                heap_keys[heap_size] = k;
                pos = heap_size;
                heap_size++;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (heap_keys[pos] <= heap_keys[up])
                        break;
                    heap_swap(pos, up);
                    pos = up;
                end
            end
        end
        else if (heap_size == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.value      = heap_keys[0];
            heap_keys[0] = heap_keys[heap_size - 1];
            heap_size--;
            pos = 0;
            while (1)
            begin
                lc  = 2 * pos + 1;
                rc  = 2 * pos + 2;
                big = pos;
                // strict compares: ties keep the parent, and the left child wins
                if (lc < heap_size && heap_keys[lc] > heap_keys[big])
                    big = lc;
                if (rc < heap_size && heap_keys[rc] > heap_keys[big])
                    big = rc;
                if (big == pos)
                    break;
                heap_swap(pos, big);
                pos = big;
            end
        end
        r.count = COUNT_W'(heap_size);
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        int unsigned             sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            // narrow range, lots of equal keys
            k = $urandom_range(0, 8);
            k = k - 4;
        end
        else if (sel < 35)
        begin
            case ($urandom_range(0, 5))
                0:       k = KEY_MAX;
                1:       k = KEY_MIN;
                2:       k = KEY_MAX - 1;
                3:       k = KEY_MIN + 1;
                4:       k = '0;
                default: k = -1;
            endcase
        end
        else
        begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic void add_op(logic act, logic signed [KEY_W-1:0] k);
        heap_op_t op;
        op.action = act;
        op.key    = k;
        pending_ops = {pending_ops, op};
        if (act == ACT_INSERT && plan_size < HEAP_DEPTH)
            plan_size++;
        else if (act == ACT_EXTRACT && plan_size > 0)
            plan_size--;
    endfunction

    function automatic void note_failure(string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus driver
    // ------------------------------------------------------------------------
    int tx_gap   = 0;
    bit tx_burst = 1'b0;

    always @(negedge clk)
    begin : driver
        heap_op_t op;
        if (rst_n)
        begin
            if (in_valid && in_acc != tx_sent)
            begin
                // still waiting on the current transaction
            end
            else if (tx_gap > 0)
            begin
                in_valid <= 1'b0;
                tx_gap--;
            end
            else if (pending_ops.size() != 0)
            begin
                op = pending_ops.pop_front();
                in_valid <= 1'b1;
                action   <= op.action;
                key      <= op.key;
                tx_sent++;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver back-pressure
    // ------------------------------------------------------------------------
    int rx_seen    = 0;
    int rx_stall   = 0;
    int hold_left  = 0;
    bit rx_burst   = 1'b0;

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (out_acc != rx_seen)
            begin
                rx_seen = out_acc;
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                // long hold-offs so the block fills up and stalls its input
                if (rx_seen == 100 || rx_seen == 700)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            else if (rx_stall > 0 && out_valid)
                rx_stall--;
            out_ready <= (hold_left == 0 && rx_stall == 0);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on input transactions, checks output transactions
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        heap_result_t exp_r;
        if (rst_n)
        begin
            idle_cycles++;
            if (out_valid && out_ready)
            begin
                idle_cycles = 0;
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("ERROR: result %0d arrived with nothing expected",
                                           out_acc));
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (value !== exp_r.value || status !== exp_r.status ||
                        count !== exp_r.count)
                        note_failure($sformatf({"ERROR: result %0d: expected value %0d ",
                            "status %0d count %0d, got value %0d status %0d count %0d"},
                            out_acc, exp_r.value, exp_r.status, exp_r.count,
                            value, status, count));
                end
                out_acc++;
            end
            if (in_valid && in_ready)
            begin
                idle_cycles = 0;
                expected_results = {expected_results, heap_apply(action, key)};
                in_acc++;
            end
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        int n_ops;
        int ins_pct;

        // directed: empty extract with a key that must be ignored
        add_op(ACT_EXTRACT, KEY_MAX);
        add_op(ACT_INSERT, KEY_MAX);
        add_op(ACT_INSERT, KEY_MIN);
        add_op(ACT_INSERT, '0);
        add_op(ACT_INSERT, -1);
        add_op(ACT_INSERT, 5);
        add_op(ACT_INSERT, 5);
        add_op(ACT_INSERT, 5);
        add_op(ACT_INSERT, 1);
        add_op(ACT_INSERT, KEY_MIN);
        add_op(ACT_EXTRACT, -1);
        while (plan_size > 0)
            add_op(ACT_EXTRACT, $urandom);
        add_op(ACT_EXTRACT, KEY_MIN);
        add_op(ACT_INSERT, 7);
        add_op(ACT_EXTRACT, 7);

        // random mix with a changing insert bias
        for (int blk = 0; blk < 2; blk++)
        begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 20;
                1:       ins_pct = 50;
                default: ins_pct = 80;
            endcase
            repeat (30)
                add_op(($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_EXTRACT,
                       pick_key());
        end

        // fill to capacity, then push a few into the full heap
        while (plan_size < HEAP_DEPTH)
            add_op(ACT_INSERT, pick_key());
        repeat (4)
            add_op(ACT_INSERT, pick_key());

        // extract-heavy mix on the deep heap
        repeat (60)
            add_op(($urandom_range(0, 99) < 30) ? ACT_INSERT : ACT_EXTRACT, pick_key());

        n_ops = pending_ops.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (in_acc < n_ops || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_cnt == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
